/* design/alignment_record_scorer_top_macros.svh */
`ifndef ALIGNMENT_RECORD_SCORER_TOP_MACROS_SVH
`define ALIGNMENT_RECORD_SCORER_TOP_MACROS_SVH

// same-cycle implication, checked on every clock edge outside reset
`define ARSC_ASSERT_SAME(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define ARSC_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* design/arsc_pkg.sv */
package arsc_pkg;

   // accumulator width for the base-match sum and the indel count
   localparam int unsigned ACC_BITS = 48;

   localparam int unsigned CSR_ADDR_BITS = 3;
   localparam int unsigned CSR_DATA_BITS = 32;

   // register index, taken from paddr[2]
   localparam logic REG_SCORING_MODE = 1'b0;

   typedef enum logic [1:0] {
      MODE_MATCH  = 2'd0,
      MODE_AS     = 2'd1,
      MODE_MAPQ   = 2'd2,
      MODE_B_WINS = 2'd3
   } scoring_mode_type;

   // item kinds
   localparam logic [1:0] KIND_CIGAR = 2'd0;
   localparam logic [1:0] KIND_MD    = 2'd1;
   localparam logic [1:0] KIND_END   = 2'd2;

   // cigar op codes
   localparam logic [3:0] OP_M     = 4'd0;
   localparam logic [3:0] OP_I     = 4'd1;
   localparam logic [3:0] OP_D     = 4'd2;
   localparam logic [3:0] OP_EQUAL = 4'd7;
   localparam logic [3:0] OP_X     = 4'd8;

   // md string characters
   localparam logic [7:0] MD_DEL_CHAR   = 8'h5E;
   localparam logic [7:0] MD_DIGIT_LOW  = 8'h30;
   localparam logic [7:0] MD_DIGIT_HIGH = 8'h39;

   localparam logic [ACC_BITS-1:0] SUM_MAX = {1'b0, {(ACC_BITS-1){1'b1}}};
   localparam logic [ACC_BITS-1:0] SUM_MIN = {1'b1, {(ACC_BITS-1){1'b0}}};
   localparam logic [31:0]         SCORE_MAX = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]         kind;
      logic [3:0]         cigar_op;
      logic [27:0]        cigar_len;
      logic [7:0]         md_char;
      logic               nm_valid;
      logic signed [31:0] nm_value;
      logic               md_valid;
      logic               as_valid;
      logic signed [31:0] as_value;
      logic [7:0]         map_quality;
      logic               is_unmapped;
      logic               from_first;
   } req_word_type;

   typedef struct packed {
      logic [31:0] score;
      logic        nm_anomaly;
      logic        no_mismatch_info;
      logic        missing_as_tag;
   } rsp_word_type;

   // running totals of the record being scored
   typedef struct packed {
      logic signed [ACC_BITS-1:0] match_sum;
      logic [ACC_BITS-1:0]        indel_bases;
      logic [31:0]                md_mismatches;
      logic                       saw_exact_ops;
   } acc_state_type;

endpackage

/* design/alignment_record_scorer_top.sv */
// Alignment record scorer. A record comes in as a run of req words: CIGAR ops, then the
// MD string one character per word, then one end word carrying NM, AS, MAPQ and flags.
// Each word lands in the input register, is then folded into the running totals, and
// an end word writes its score into the output register at the same edge as that fold,
// so a new word is taken every cycle while rsp_ready holds. The only stall comes from
// an end word meeting a full output register that is not being drained. One rsp word
// per end word; CIGAR and MD words give none. Scoring mode is set through the APB
// register at address 0; the user must change it only with the block idle, as the
// block itself does not enforce this.
`include "alignment_record_scorer_top_macros.svh"

module alignment_record_scorer_top
   import arsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   // input words
   input  logic                     req_valid,
   output logic                     req_ready,
   input  req_word_type             req_word,
   // result words
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output rsp_word_type             rsp_word,
   // register port
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready
);

   // input register
   req_word_type     item_ff, item_in;
   logic             item_valid_ff, item_valid_in;
   // output register
   rsp_word_type     rsp_word_ff, rsp_word_in;
   logic             rsp_valid_ff, rsp_valid_in;

   scoring_mode_type mode;
   acc_state_type    acc_state;
   rsp_word_type     result;
   logic             is_end;
   logic             out_free;
   logic             fire;
   logic             fire_end;

   arsc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .mode    (mode)
   );

   // running totals for the current record
   arsc_accum u_accum (
      .clock (clock),
      .reset (reset),
      .step  (fire),
      .item  (item_ff),
      .state (acc_state)
   );

   // end-of-record scoring, straight from the totals and the end word
   arsc_score u_score (
      .mode   (mode),
      .state  (acc_state),
      .item   (item_ff),
      .result (result)
   );

   assign is_end   = (item_ff.kind == KIND_END);
   // output slot free now or freed by this edge's handoff
   assign out_free = !rsp_valid_ff || rsp_ready;
   // the word in the input register is used up this cycle
   assign fire     = item_valid_ff && (!is_end || out_free);
   assign fire_end = fire && is_end;

   assign req_ready = !item_valid_ff || fire;

   always_comb begin
      item_in       = item_ff;
      item_valid_in = item_valid_ff;
      if (req_valid && req_ready) begin
         item_in       = req_word;
         item_valid_in = 1'b1;
      end else if (fire) begin
         item_valid_in = 1'b0;
      end
   end

   always_comb begin
      rsp_word_in  = rsp_word_ff;
      rsp_valid_in = rsp_valid_ff;
      if (fire_end) begin
         rsp_word_in  = result;
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      // payload, no reset needed
      item_ff     <= item_in;
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

   // a result only ever appears from an end word that was scored
   `ARSC_ASSERT_SAME(a_rsp_from_end, $rose(rsp_valid_ff), $past(fire_end),
      "result word without a scored end word")
   // AS flag means score zero and no match-mode flags
   `ARSC_ASSERT_SAME(a_as_flag, rsp_valid_ff && rsp_word_ff.missing_as_tag,
      (rsp_word_ff.score == '0) && !rsp_word_ff.nm_anomaly && !rsp_word_ff.no_mismatch_info,
      "missing AS tag with nonzero score or match-mode flag")
   // a word held in the input register is not overwritten
   `ARSC_ASSERT_NEXT(a_item_held, item_valid_ff && !fire,
      item_valid_ff && (item_ff == $past(item_ff)), "held input word lost or changed")

endmodule

/* design/arsc_accum.sv */
`include "alignment_record_scorer_top_macros.svh"

module arsc_accum
   import arsc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          step,
   input  req_word_type  item,
   output acc_state_type state
);

   logic signed [ACC_BITS-1:0] match_sum_ff, match_sum_in;
   logic [ACC_BITS-1:0]        indel_ff, indel_in;
   logic [31:0]                md_ff, md_in;
   logic                       exact_ff, exact_in;
   logic                       del_ff, del_in;

   logic [ACC_BITS-1:0]        len_ext;
   logic signed [ACC_BITS:0]   sum_up;
   logic signed [ACC_BITS:0]   sum_down;
   logic [ACC_BITS:0]          indel_up;
   logic signed [ACC_BITS-1:0] sum_up_sat;
   logic signed [ACC_BITS-1:0] sum_down_sat;
   logic [ACC_BITS-1:0]        indel_up_sat;
   logic                       is_digit;

   assign len_ext  = ACC_BITS'(item.cigar_len);
   assign sum_up   = $signed({match_sum_ff[ACC_BITS-1], match_sum_ff}) + $signed({1'b0, len_ext});
   assign sum_down = $signed({match_sum_ff[ACC_BITS-1], match_sum_ff}) - $signed({1'b0, len_ext});
   assign indel_up = {1'b0, indel_ff} + {1'b0, len_ext};

   // overflow shows as the two top bits disagreeing
   assign sum_up_sat   = (sum_up[ACC_BITS] != sum_up[ACC_BITS-1]) ?
                         $signed(SUM_MAX) : sum_up[ACC_BITS-1:0];
   assign sum_down_sat = (sum_down[ACC_BITS] != sum_down[ACC_BITS-1]) ?
                         $signed(SUM_MIN) : sum_down[ACC_BITS-1:0];
   assign indel_up_sat = indel_up[ACC_BITS] ? {ACC_BITS{1'b1}} : indel_up[ACC_BITS-1:0];

   assign is_digit = (item.md_char >= MD_DIGIT_LOW) && (item.md_char <= MD_DIGIT_HIGH);

   always_comb begin
      match_sum_in = match_sum_ff;
      indel_in     = indel_ff;
      md_in        = md_ff;
      exact_in     = exact_ff;
      del_in       = del_ff;
      if (step) begin
         unique case (item.kind)
            KIND_CIGAR: begin
               unique case (item.cigar_op)
                  OP_EQUAL: begin
                     exact_in     = 1'b1;
                     match_sum_in = sum_up_sat;
                  end
                  OP_M: match_sum_in = sum_up_sat;
                  OP_D: begin
                     match_sum_in = sum_down_sat;
                     indel_in     = indel_up_sat;
                  end
                  OP_I: indel_in = indel_up_sat;
                  OP_X: exact_in = 1'b1;
                  default: ;
               endcase
            end
            KIND_MD: begin
               priority if (item.md_char == MD_DEL_CHAR) begin
                  del_in = 1'b1;
               end else if (is_digit) begin
                  del_in = 1'b0;
               end else begin
                  if (!del_ff && (md_ff != 32'hFFFF_FFFF)) begin
                     md_in = md_ff + 32'd1;
                  end
               end
            end
            KIND_END: begin
               match_sum_in = '0;
               indel_in     = '0;
               md_in        = '0;
               exact_in     = 1'b0;
               del_in       = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         match_sum_ff <= '0;
         indel_ff     <= '0;
         md_ff        <= '0;
         exact_ff     <= 1'b0;
         del_ff       <= 1'b0;
      end else begin
         match_sum_ff <= match_sum_in;
         indel_ff     <= indel_in;
         md_ff        <= md_in;
         exact_ff     <= exact_in;
         del_ff       <= del_in;
      end
   end

   assign state.match_sum     = match_sum_ff;
   assign state.indel_bases   = indel_ff;
   assign state.md_mismatches = md_ff;
   assign state.saw_exact_ops = exact_ff;

   `ARSC_ASSERT_NEXT(a_end_clears, step && (item.kind == KIND_END),
      (match_sum_ff == '0) && (indel_ff == '0) && (md_ff == '0) && !exact_ff && !del_ff,
      "record totals not cleared after end word")
   `ARSC_ASSERT_NEXT(a_indel_grows, step && (item.kind != KIND_END),
      indel_ff >= $past(indel_ff), "indel count dropped inside a record")

endmodule

/* design/arsc_score.sv */
module arsc_score
   import arsc_pkg::*;
(
   input  scoring_mode_type mode,
   input  acc_state_type    state,
   input  req_word_type     item,
   output rsp_word_type     result
);

   localparam int unsigned TOT_BITS = ACC_BITS + 2;

   logic signed [TOT_BITS-1:0] base;
   logic signed [TOT_BITS-1:0] nm_total;
   logic signed [TOT_BITS-1:0] md_total;
   logic signed [TOT_BITS-1:0] total;
   logic                       nm_lt;
   logic                       use_nm;
   logic                       use_md;
   logic                       nm_bad;
   logic                       no_info;
   logic [31:0]                match_score;
   logic [31:0]                b_wins_score;

   assign base     = $signed({{2{state.match_sum[ACC_BITS-1]}}, state.match_sum});
   // nm correction: sum - (nm - indel), only used when nm >= indel
   assign nm_total = base + $signed({2'b00, state.indel_bases})
                   - $signed({{(TOT_BITS-32){1'b0}}, item.nm_value});
   assign md_total = base - $signed({{(TOT_BITS-32){1'b0}}, state.md_mismatches});

   assign nm_lt   = item.nm_value[31] ||
                    ({{(ACC_BITS-32){1'b0}}, item.nm_value} < state.indel_bases);
   assign nm_bad  = !state.saw_exact_ops && item.nm_valid && nm_lt;
   assign use_nm  = !state.saw_exact_ops && item.nm_valid && !nm_lt;
   assign use_md  = !state.saw_exact_ops && !use_nm && item.md_valid;
   assign no_info = !state.saw_exact_ops && !use_nm && !use_md;

   assign total = use_nm ? nm_total : (use_md ? md_total : base);

   // clamp to 0 .. 2^31-1
   always_comb begin
      priority if (total[TOT_BITS-1]) begin
         match_score = '0;
      end else if (|total[TOT_BITS-2:31]) begin
         match_score = SCORE_MAX;
      end else begin
         match_score = {1'b0, total[30:0]};
      end
   end

   assign b_wins_score = item.from_first ? 32'd1 : (item.is_unmapped ? 32'd0 : 32'd2);

   always_comb begin
      result = '0;
      unique case (mode)
         MODE_MATCH: begin
            result.score            = match_score;
            result.nm_anomaly       = nm_bad;
            result.no_mismatch_info = no_info;
         end
         MODE_AS: begin
            result.score          = item.as_valid ? item.as_value : 32'd0;
            result.missing_as_tag = !item.as_valid;
         end
         MODE_MAPQ:   result.score = {24'd0, item.map_quality};
         MODE_B_WINS: result.score = b_wins_score;
      endcase
   end

endmodule

/* design/arsc_csr.sv */
module arsc_csr
   import arsc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_BITS-1:0] paddr,
   input  logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0] prdata,
   output logic                     pready,
   output scoring_mode_type         mode
);

   scoring_mode_type mode_ff, mode_in;
   logic             reg_index;
   logic             wr_mode;

   assign pready    = 1'b1;
   assign reg_index = paddr[2];
   assign wr_mode   = psel && penable && pwrite && (reg_index == REG_SCORING_MODE);

   assign mode_in = wr_mode ? scoring_mode_type'(pwdata[1:0]) : mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_MATCH;
      end else begin
         mode_ff <= mode_in;
      end
   end

   assign prdata = (reg_index == REG_SCORING_MODE) ?
                   {{(CSR_DATA_BITS-2){1'b0}}, mode_ff} : '0;
   assign mode   = mode_ff;

endmodule
